// ===== rtl/core/keyed_device_registry_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Keyed device registry table - assertion macros
// Checks that are written once here and used by the registry RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_DEVICE_REGISTRY_TABLE_TOP_MACROS_SVH
`define KEYED_DEVICE_REGISTRY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define KDRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define KDRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kdrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed device registry table - package
// Operation and status codes and the field types of the registry ports.
// ----------------------------------------------------------------------------
`default_nettype none

package kdrt_pkg;

  typedef logic [2:0]  op_t;
  typedef logic [2:0]  status_t;
  typedef logic [3:0]  slot_t;
  typedef logic [31:0] serial_t;
  typedef logic [31:0] key_t;
  typedef logic [7:0]  dtype_t;
  typedef logic [4:0]  count_t;

  localparam op_t OP_ADD    = 3'd0;
  localparam op_t OP_REMOVE = 3'd1;
  localparam op_t OP_FIND   = 3'd2;
  localparam op_t OP_REKEY  = 3'd3;
  localparam op_t OP_READ   = 3'd4;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_BADSLOT  = 3'd2;
  localparam status_t ST_TAKEN    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/keyed_device_registry_table_top.sv =====
// ----------------------------------------------------------------------------
// Keyed device registry table - top level
// Table of device entries with serial lookup, first-free allocation,
// removal, rekeying and readback, driven by a small scan sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Words carried
//  --------  ----------------  ------------------------------------------------
//  in_*      start / busy      operation, slot, serial, dev_key, dev_type
//  out_*     out_valid strobe  status, result_slot, was_existing, read_serial,
//                              read_key, read_type, slots_in_use
//
// A word is taken at a clock edge with start high and busy low. Busy then stays
// high until the result word is produced, and the result strobe rises in the
// cycle that busy falls, so a new word can be taken in that very cycle.
// Add, find and rekey compare one slot per cycle against the serial memory, over
// the slots below the high-water count (at most ENTRIES); a hit ends the scan
// early. Remove and a rekey or read of an unusable slot finish in the dispatch
// state; a read of a usable slot goes on to a read-data state first.
// Reset (rst_n low, synchronous) clears all valid marks and the count at once.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_device_registry_table_top_macros.svh"

module keyed_device_registry_table_top #(
  parameter int ENTRIES = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  kdrt_pkg::op_t        in_operation,
  input  kdrt_pkg::slot_t      in_slot,
  input  kdrt_pkg::serial_t    in_serial,
  input  kdrt_pkg::key_t       in_dev_key,
  input  kdrt_pkg::dtype_t     in_dev_type,
  output logic                 out_valid,
  output kdrt_pkg::status_t    out_status,
  output kdrt_pkg::slot_t      out_result_slot,
  output logic                 out_was_existing,
  output kdrt_pkg::serial_t    out_read_serial,
  output kdrt_pkg::key_t       out_read_key,
  output kdrt_pkg::dtype_t     out_read_type,
  output kdrt_pkg::count_t     out_slots_in_use
);

  import kdrt_pkg::*;

  // Index width into the table, and width of a count that can reach ENTRIES.
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HW = $clog2(ENTRIES + 1);
  // Common width for comparing a 4-bit slot number against counts and indexes.
  localparam int CW = (HW > 4) ? HW : 4;
  localparam logic [HW-1:0] ENT_W = HW'(ENTRIES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Captured input word.
  op_t     op_r;
  slot_t   slot_r;
  serial_t serial_r;
  key_t    key_r;
  dtype_t  type_r;

  // Table state: valid marks in flops, payload in memories.
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [HW-1:0]      hw_r, hw_nxt;
  serial_t            mem_serial [ENTRIES];
  key_t               mem_key    [ENTRIES];
  dtype_t             mem_type   [ENTRIES];

  // Memory port controls and registered read data.
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  serial_t       rd_serial_q;
  key_t          rd_key_q;
  dtype_t        rd_type_q;
  logic          rd_valid_q;
  logic          wr_serial_en;
  logic          wr_kt_en;
  logic [IW-1:0] wr_addr;

  // Scan bookkeeping: issue index, the slot whose data is in the read
  // register, and the first hit and first free slot seen so far.
  logic [HW-1:0] idx_r, idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  // Result word registers.
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  logic    out_exist_r, out_exist_nxt;
  serial_t out_rserial_r, out_rserial_nxt;
  key_t    out_rkey_r, out_rkey_nxt;
  dtype_t  out_rtype_r, out_rtype_nxt;
  count_t  out_count_r, out_count_nxt;

  // Helper terms.
  logic          slot_ok;
  logic          hit_now;
  logic          issue_go;
  logic          have_free;
  logic [IW-1:0] claim_idx;
  logic [HW-1:0] claim_top;

  assign busy = (state_r != S_IDLE);

  // A slot is usable when it lies under the high-water count and is valid.
  assign slot_ok = (CW'(slot_r) < CW'(hw_r)) && valid_r[IW'(slot_r)];

  // The read register holds slot cmp_idx_r; a hit is a valid entry whose serial
  // matches. The scan stops at the first one, which is the lowest.
  assign hit_now  = cmp_vld_r && rd_valid_q && (rd_serial_q == serial_r);
  assign issue_go = (idx_r < hw_r) && !hit_now;

  // Everything at or above the count is free, so with no free slot seen below
  // the count the next claim goes at the count itself, if the table has room.
  assign have_free = free_r || (hw_r < ENT_W);
  assign claim_idx = free_r ? free_idx_r : IW'(hw_r);
  assign claim_top = HW'(claim_idx) + HW'(1);

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    hw_nxt          = hw_r;
    idx_nxt         = idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r[IW-1:0];
    wr_serial_en    = 1'b0;
    wr_kt_en        = 1'b0;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_exist_nxt   = out_exist_r;
    out_rserial_nxt = out_rserial_r;
    out_rkey_nxt    = out_rkey_r;
    out_rtype_nxt   = out_rtype_r;
    out_count_nxt   = out_count_r;
    wr_addr         = IW'(slot_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        // Default result: bad slot, fields cleared, count unchanged.
        out_status_nxt  = ST_BADSLOT;
        out_slot_nxt    = slot_r;
        out_exist_nxt   = 1'b0;
        out_rserial_nxt = '0;
        out_rkey_nxt    = '0;
        out_rtype_nxt   = '0;
        out_count_nxt   = 5'(hw_r);
        idx_nxt         = '0;
        cmp_vld_nxt     = 1'b0;
        hit_nxt         = 1'b0;
        free_nxt        = 1'b0;
        unique case (op_r)
          OP_ADD, OP_FIND: begin
            state_nxt = S_SCAN;
          end
          OP_REMOVE: begin
            if (slot_ok) begin
              valid_nxt[IW'(slot_r)] = 1'b0;
              out_status_nxt         = ST_OK;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          OP_REKEY: begin
            if (slot_ok) begin
              state_nxt = S_SCAN;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_READ: begin
            if (slot_ok) begin
              rd_en     = 1'b1;
              rd_addr   = IW'(slot_r);
              state_nxt = S_RDATA;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            out_slot_nxt  = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // One slot read is issued and the previous one compared each cycle.
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          if (cmp_vld_r && !rd_valid_q && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (issue_go) begin
            rd_en       = 1'b1;
            rd_addr     = idx_r[IW-1:0];
            idx_nxt     = idx_r + HW'(1);
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = idx_r[IW-1:0];
          end else begin
            cmp_vld_nxt = 1'b0;
            if (!cmp_vld_r) begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r)
          OP_ADD: begin
            if (hit_r) begin
              wr_kt_en       = 1'b1;
              wr_addr        = hit_idx_r;
              out_status_nxt = ST_OK;
              out_slot_nxt   = 4'(hit_idx_r);
              out_exist_nxt  = 1'b1;
            end else if (have_free) begin
              wr_serial_en         = 1'b1;
              wr_kt_en             = 1'b1;
              wr_addr              = claim_idx;
              valid_nxt[claim_idx] = 1'b1;
              if (claim_top > hw_r) begin
                hw_nxt = claim_top;
              end
              out_status_nxt = ST_OK;
              out_slot_nxt   = 4'(claim_idx);
              out_count_nxt  = 5'((claim_top > hw_r) ? claim_top : hw_r);
            end else begin
              out_status_nxt = ST_FULL;
              out_slot_nxt   = '0;
            end
          end
          OP_FIND: begin
            if (hit_r) begin
              out_status_nxt = ST_OK;
              out_slot_nxt   = 4'(hit_idx_r);
            end else begin
              out_status_nxt = ST_NOTFOUND;
              out_slot_nxt   = '0;
            end
          end
          default: begin
            // Rekey: a serial held by another slot is refused.
            if (hit_r && (CW'(hit_idx_r) != CW'(slot_r))) begin
              out_status_nxt = ST_TAKEN;
            end else begin
              wr_serial_en   = 1'b1;
              wr_kt_en       = 1'b1;
              wr_addr        = IW'(slot_r);
              out_status_nxt = ST_OK;
            end
          end
        endcase
      end

      S_RDATA: begin
        out_status_nxt  = ST_OK;
        out_rserial_nxt = rd_serial_q;
        out_rkey_nxt    = rd_key_q;
        out_rtype_nxt   = rd_type_q;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= in_operation;
      slot_r   <= in_slot;
      serial_r <= in_serial;
      key_r    <= in_dev_key;
      type_r   <= in_dev_type;
    end
    idx_r         <= idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    free_idx_r    <= free_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_exist_r   <= out_exist_nxt;
    out_rserial_r <= out_rserial_nxt;
    out_rkey_r    <= out_rkey_nxt;
    out_rtype_r   <= out_rtype_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Entry memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_serial_en) begin
      mem_serial[wr_addr] <= serial_r;
    end
    if (wr_kt_en) begin
      mem_key[wr_addr]  <= key_r;
      mem_type[wr_addr] <= type_r;
    end
    if (rd_en) begin
      rd_serial_q <= mem_serial[rd_addr];
      rd_key_q    <= mem_key[rd_addr];
      rd_type_q   <= mem_type[rd_addr];
      rd_valid_q  <= valid_r[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_slot  = out_slot_r;
  assign out_was_existing = out_exist_r;
  assign out_read_serial  = out_rserial_r;
  assign out_read_key     = out_rkey_r;
  assign out_read_type    = out_rtype_r;
  assign out_slots_in_use = out_count_r;

  // A result word only follows a cycle of work.
  `KDRT_ASSERT_NOW(a_out_after_work, out_valid_r, $past(state_r != S_IDLE), "result without work")
  // A taken word makes the block busy in the next cycle.
  `KDRT_ASSERT_NXT(a_busy_after_start, start && !busy, busy, "start not taken")
  // The high-water count never passes the table size.
  `KDRT_ASSERT_NOW(a_hw_bound, 1'b1, hw_r <= ENT_W, "count above table size")
  // No slot at or above the count is ever valid.
  `KDRT_ASSERT_NOW(a_valid_below_hw, 1'b1, (valid_r >> hw_r) == '0, "valid slot above count")

endmodule

`default_nettype wire
